// ===== rtl/lkh_pkg.sv =====
// Package for the lookup2 key hash: constants, register indexes, the job
// record passed from front to back, and the single mix step function.
// No dependencies.
`timescale 1ns / 1ps

package lkh_pkg;

  // Hash constants.
  localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
  localparam logic [31:0] SECRET_RESET = 32'h0F937A21;

  // Key block geometry.
  localparam int BLOCK_BYTES = 12;
  localparam int FILL_W      = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED   = 2'd0,
    REG_SECRET = 2'd1
  } cfg_reg_e;

  // Mixer sequencing: nine dependent steps, one per cycle.
  localparam int MIX_STEPS = 9;
  localparam int STEP_W    = 4;

  // Job queue between front and back.
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_t;

  // One unit of work for the back end. The words are added to the mix
  // state, then the state is mixed. With twice set, the length is added
  // to c and a second mix follows. With fin set, c is the key's hash.
  typedef struct packed {
    logic        init;
    logic [31:0] init_c;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
    logic        twice;
    logic [31:0] len2;
    logic        fin;
  } job_t;

  // One step of the lookup2 mix; the step number selects the word and shift.
  function automatic mix_t mix_step(input logic [STEP_W-1:0] k, input mix_t m);
    mix_t r;
    r = m;
    case (k)
      4'd0:    r.a = (m.a - m.b - m.c) ^ (m.c >> 13);
      4'd1:    r.b = (m.b - m.c - m.a) ^ (m.a << 8);
      4'd2:    r.c = (m.c - m.a - m.b) ^ (m.b >> 13);
      4'd3:    r.a = (m.a - m.b - m.c) ^ (m.c >> 12);
      4'd4:    r.b = (m.b - m.c - m.a) ^ (m.a << 16);
      4'd5:    r.c = (m.c - m.a - m.b) ^ (m.b >> 5);
      4'd6:    r.a = (m.a - m.b - m.c) ^ (m.c >> 3);
      4'd7:    r.b = (m.b - m.c - m.a) ^ (m.a << 10);
      4'd8:    r.c = (m.c - m.a - m.b) ^ (m.b >> 15);
      default: r = m;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lkh_front.sv =====
// Front end of the lookup2 key hash: takes key bytes, gathers 12-byte
// blocks, counts the length, holds seed and secret, and issues jobs.
// Depends on lkh_pkg.
`timescale 1ns / 1ps

module lkh_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lkh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    key_byte_i,
  input  logic                          has_byte_i,
  input  logic                          last_i,
  output logic                          job_valid_o,
  output lkh_pkg::job_t                 job_o,
  input  logic                          job_ready_i
);

  logic [31:0] seed_q, seed_d, secret_q, secret_d;
  logic        in_key_q, in_key_d;
  logic        first_q, first_d;
  logic [lkh_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  blk_q [lkh_pkg::BLOCK_BYTES];

  logic        acc, work, open, first, full, push;
  logic [lkh_pkg::FILL_W-1:0] fill_base, fill_new;
  logic [31:0] len_base, len_new;
  logic [7:0]  nb [lkh_pkg::BLOCK_BYTES];
  logic [7:0]  tb [lkh_pkg::BLOCK_BYTES];

  // An item may enter whenever the job queue has room.
  assign in_ready_o = job_ready_i;
  assign acc  = in_valid_i & job_ready_i;
  assign work = acc & (has_byte_i | last_i);

  // A key opens on its first item with a byte or an end mark.
  assign open      = ~in_key_q;
  assign first     = open | first_q;
  assign fill_base = open ? '0 : fill_q;
  assign len_base  = open ? '0 : len_q;
  assign fill_new  = fill_base + {{(lkh_pkg::FILL_W-1){1'b0}}, has_byte_i};
  assign len_new   = len_base + {31'b0, has_byte_i};
  assign full      = has_byte_i &&
                     (fill_new == lkh_pkg::FILL_W'(lkh_pkg::BLOCK_BYTES));
  assign push      = work & (full | last_i);

  // Block bytes as they stand after this item, and the tail with unused
  // places forced to zero.
  always_comb begin
    for (int i = 0; i < lkh_pkg::BLOCK_BYTES; i++) begin
      nb[i] = (has_byte_i && (fill_base == lkh_pkg::FILL_W'(i))) ? key_byte_i : blk_q[i];
      tb[i] = (lkh_pkg::FILL_W'(i) < fill_new) ? nb[i] : 8'h00;
    end
  end

  // Job assembly: a full block, a tail with the length, or both.
  always_comb begin
    job_o.init   = first;
    job_o.init_c = seed_q ^ secret_q;
    job_o.fin    = last_i;
    job_o.len2   = len_new;
    if (full) begin
      job_o.add_a = {nb[3], nb[2], nb[1], nb[0]};
      job_o.add_b = {nb[7], nb[6], nb[5], nb[4]};
      job_o.add_c = {nb[11], nb[10], nb[9], nb[8]};
      job_o.twice = last_i;
    end else begin
      job_o.add_a = {tb[3], tb[2], tb[1], tb[0]};
      job_o.add_b = {tb[7], tb[6], tb[5], tb[4]};
      job_o.add_c = {tb[10], tb[9], tb[8], 8'h00} + len_new;
      job_o.twice = 1'b0;
    end
  end

  assign job_valid_o = push;

  // Configuration writes; indexes beyond the list are dropped.
  always_comb begin
    seed_d   = seed_q;
    secret_d = secret_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lkh_pkg::REG_SEED:   seed_d   = cfg_wdata_i;
        lkh_pkg::REG_SECRET: secret_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Key tracking state.
  always_comb begin
    in_key_d = in_key_q;
    first_d  = first_q;
    fill_d   = fill_q;
    len_d    = len_q;
    if (work) begin
      in_key_d = ~last_i;
      first_d  = push ? 1'b0 : first;
      fill_d   = full ? '0 : fill_new;
      len_d    = len_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      secret_q <= lkh_pkg::SECRET_RESET;
      in_key_q <= 1'b0;
      first_q  <= 1'b0;
      fill_q   <= '0;
      len_q    <= '0;
    end else begin
      seed_q   <= seed_d;
      secret_q <= secret_d;
      in_key_q <= in_key_d;
      first_q  <= first_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
    end
  end

  // Byte store: one write per item that carries a byte.
  always_ff @(posedge clk_i) begin
    if (acc && has_byte_i) begin
      blk_q[fill_base] <= key_byte_i;
    end
  end

endmodule

// ===== rtl/lkh_fifo.sv =====
// Two-entry job queue between the front and back ends of the key hash.
// Depends on lkh_pkg.
`timescale 1ns / 1ps

module lkh_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  lkh_pkg::job_t wr_job_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output lkh_pkg::job_t rd_job_o
);

  lkh_pkg::job_t mem_q [lkh_pkg::FIFO_DEPTH];
  logic [lkh_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [lkh_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign wr_ready_o = (cnt_q != lkh_pkg::CNT_W'(lkh_pkg::FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i & wr_ready_o;
  assign do_rd      = rd_valid_o & rd_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == lkh_pkg::PTR_W'(lkh_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == lkh_pkg::PTR_W'(lkh_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

// ===== rtl/lkh_back.sv =====
// Back end of the key hash: holds the a, b, c mix state, adds each job's
// words, runs the mix one step per cycle and registers the hash result.
// Depends on lkh_pkg.
`timescale 1ns / 1ps

module lkh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  lkh_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   hash_value_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_TAIL = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  lkh_pkg::mix_t m_q, m_d, base, stepped;
  logic [lkh_pkg::STEP_W-1:0] step_q, step_d;
  logic        twice_q, twice_d, fin_q, fin_d;
  logic [31:0] len2_q, len2_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        last_step;

  assign job_ready_o  = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_data_q;

  // A new key starts from the golden ratio and the seed word XORed with the secret.
  always_comb begin
    if (job_i.init) begin
      base.a = lkh_pkg::GOLDEN_RATIO;
      base.b = lkh_pkg::GOLDEN_RATIO;
      base.c = job_i.init_c;
    end else begin
      base = m_q;
    end
  end

  assign stepped   = lkh_pkg::mix_step(step_q, m_q);
  assign last_step = (step_q == lkh_pkg::STEP_W'(lkh_pkg::MIX_STEPS - 1));

  // Sequencer: load, nine mix steps, optional length add and second mix, result on a key end.
  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    step_d      = step_q;
    twice_d     = twice_q;
    fin_d       = fin_q;
    len2_d      = len2_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          m_d.a   = base.a + job_i.add_a;
          m_d.b   = base.b + job_i.add_b;
          m_d.c   = base.c + job_i.add_c;
          step_d  = '0;
          twice_d = job_i.twice;
          fin_d   = job_i.fin;
          len2_d  = job_i.len2;
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        m_d    = stepped;
        step_d = step_q + 1'b1;
        if (last_step) begin
          if (twice_q) begin
            state_d = S_TAIL;
          end else if (fin_q) begin
            state_d = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        m_d.c   = m_q.c + len2_q;
        step_d  = '0;
        twice_d = 1'b0;
        state_d = S_MIX;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = m_q.c;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      twice_q     <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      twice_q     <= twice_d;
      fin_q       <= fin_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    len2_q     <= len2_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== rtl/lookup2_key_hash.sv =====
// Top level of the lookup2 key hash: front end, job queue and back end.
// Depends on lkh_pkg, lkh_front, lkh_fifo and lkh_back.
//
//   Channel   Direction  Item content
//   s_axis    in         tdata: key_byte; tuser: has_byte; tlast: last
//   m_axis    out        tdata: hash_value
//   cfg       in         write of seed (index 0) or secret (index 1)
//
// Key bytes are taken one per cycle while the two-entry job queue has room.
// The back end mixes with one shared step unit, one step per cycle, and
// takes a job only while idle; a last byte that closes a 12-byte block gets
// a second mix after the length is added, and a key end puts out its hash.
// Reset is asynchronous and needs no clearing pass.
// A stalled result holds in the output register while new bytes still enter.
`timescale 1ns / 1ps

module lookup2_key_hash (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lkh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lkh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] key_byte
  input  logic                           s_axis_tuser,   // [0] has_byte
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata    // [31:0] hash_value
);

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  lkh_pkg::job_t fj_job, bj_job;

  // Byte intake and block assembly.
  lkh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .key_byte_i  (s_axis_tdata),
    .has_byte_i  (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .job_valid_o (fj_valid),
    .job_o       (fj_job),
    .job_ready_i (fj_ready)
  );

  // Job queue.
  lkh_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fj_valid),
    .wr_ready_o (fj_ready),
    .wr_job_i   (fj_job),
    .rd_valid_o (bj_valid),
    .rd_ready_i (bj_ready),
    .rd_job_o   (bj_job)
  );

  // Mixer and result register.
  lkh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (bj_valid),
    .job_ready_o  (bj_ready),
    .job_i        (bj_job),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .hash_value_o (m_axis_tdata)
  );

endmodule

// ===== rtl/lkh_checker.sv =====
// Port-level checker for the lookup2 key hash, bound to the top level.
// Depends on lookup2_key_hash.
`timescale 1ns / 1ps

module lkh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [2:0] pend_q, pend_d;
  logic       key_end, res_take;

  // Keys ended at the input whose hash has not yet been taken.
  assign key_end  = s_axis_tvalid & s_axis_tready & s_axis_tlast;
  assign res_take = m_axis_tvalid & m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (key_end && !res_take) begin
      pend_d = pend_q + 1'b1;
    end else if (!key_end && res_take) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every result belongs to a key that has ended.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> pend_q != 3'd0)
    else $error("result without an ended key");

  // Queue, mixer and output register hold at most four ended keys.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("too many keys in flight");

endmodule

bind lookup2_key_hash lkh_checker u_lkh_checker (.*);
